### rtl/core/drt_pkg.sv
// Shared types and codes for the damage rectangle tracker.
`default_nettype none
package drt_pkg;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DRAIN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
	} cmd_t;

	typedef struct packed {
		logic scan_need;
		logic last;
	} stat_t;

endpackage
`default_nettype wire

### rtl/core/damage_rect_tracker.sv
// Top level of the damage rectangle tracker.
// Add, clear, unknown operations, and a query on an empty list or with overflow set:
// done strobes in RESP, reached through EXEC after accept, busy drops the cycle after; start is taken only in IDLE.
// Other queries: done strobes in RESP, reached through EXEC, SCAN and DRAIN; SCAN reads the n stored entries one per
// cycle from the single-port rectangle store; start is taken again only in IDLE.
// Results cannot be stalled. Asynchronous reset empties the list and clears overflow.
`default_nettype none
module damage_rect_tracker #(
	parameter int MAX_RECTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         operation,
	input  wire logic signed [15:0] rect_x,
	input  wire logic signed [15:0] rect_y,
	input  wire logic [15:0]        rect_w,
	input  wire logic [15:0]        rect_h,
	output logic                    done,
	output logic                    hit,
	output logic [1:0]              status,
	output logic [4:0]              entries
);

	drt_pkg::cmd_t  cmd;
	drt_pkg::stat_t stat;

	drt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	drt_dp #(
		.MAX_RECTS (MAX_RECTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operation (operation),
		.rect_x    (rect_x),
		.rect_y    (rect_y),
		.rect_w    (rect_w),
		.rect_h    (rect_h),
		.stat      (stat),
		.hit       (hit),
		.status    (status),
		.entries   (entries)
	);

endmodule
`default_nettype wire

### rtl/core/drt_ctrl.sv
// Controller state machine for the damage rectangle tracker.
`default_nettype none
module drt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire drt_pkg::stat_t stat,
	output drt_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);

	drt_pkg::state_t state_q;
	drt_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drt_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			drt_pkg::S_IDLE: begin
				if (start) begin
					state_nxt = drt_pkg::S_EXEC;
				end
			end
			drt_pkg::S_EXEC: begin
				state_nxt = stat.scan_need ? drt_pkg::S_SCAN : drt_pkg::S_RESP;
			end
			drt_pkg::S_SCAN: begin
				if (stat.last) begin
					state_nxt = drt_pkg::S_DRAIN;
				end
			end
			drt_pkg::S_DRAIN: begin
				state_nxt = drt_pkg::S_RESP;
			end
			drt_pkg::S_RESP: begin
				state_nxt = drt_pkg::S_IDLE;
			end
			default: begin
				state_nxt = drt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.load = (state_q == drt_pkg::S_IDLE) && start;
		cmd.exec = (state_q == drt_pkg::S_EXEC);
		cmd.scan = (state_q == drt_pkg::S_SCAN);
		busy     = (state_q != drt_pkg::S_IDLE);
		done     = (state_q == drt_pkg::S_RESP);
	end

endmodule
`default_nettype wire

### rtl/core/drt_dp.sv
// Datapath of the damage rectangle tracker: rectangle store, count and overlap test.
`default_nettype none
module drt_dp #(
	parameter int MAX_RECTS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire drt_pkg::cmd_t        cmd,
	input  wire logic [1:0]           operation,
	input  wire logic signed [15:0]   rect_x,
	input  wire logic signed [15:0]   rect_y,
	input  wire logic [15:0]          rect_w,
	input  wire logic [15:0]          rect_h,
	output drt_pkg::stat_t            stat,
	output logic                      hit,
	output logic [1:0]                status,
	output logic [4:0]                entries
);

	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

	logic [63:0]        mem [0:MAX_RECTS-1];
	logic [63:0]        rd_s1;
	logic               valid_s1;

	drt_pkg::op_t       op_q;
	logic signed [15:0] x_q;
	logic signed [15:0] y_q;
	logic [15:0]        w_q;
	logic [15:0]        h_q;

	logic [CW-1:0]      count_q;
	logic               ovf_q;
	logic [IW-1:0]      idx_q;
	logic               hit_q;
	drt_pkg::status_t   status_q;

	logic               empty_add;
	logic               full;
	logic               wr_en;
	logic [CW+4:0]      count_ext;

	logic signed [17:0] qx, qy, qr, qb;
	logic signed [17:0] sx, sy, sr, sb;
	logic               overlap;

	assign empty_add = (w_q == 16'd0) || (h_q == 16'd0);
	assign full      = (count_q >= CW'(MAX_RECTS));
	assign wr_en     = cmd.exec && (op_q == drt_pkg::OP_ADD) && !empty_add && !full;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= drt_pkg::op_t'(operation);
			x_q  <= rect_x;
			y_q  <= rect_y;
			w_q  <= rect_w;
			h_q  <= rect_h;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IW-1:0]] <= {x_q, y_q, w_q, h_q};
		end
		if (cmd.scan) begin
			rd_s1 <= mem[idx_q];
		end
	end

	always_comb begin
		qx = 18'(x_q);
		qy = 18'(y_q);
		qr = qx + $signed({2'b00, w_q});
		qb = qy + $signed({2'b00, h_q});
		sx = 18'($signed(rd_s1[63:48]));
		sy = 18'($signed(rd_s1[47:32]));
		sr = sx + $signed({2'b00, rd_s1[31:16]});
		sb = sy + $signed({2'b00, rd_s1[15:0]});
		overlap = !((sx >= qr) || (sr <= qx) || (sy >= qb) || (sb <= qy));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			hit_q    <= 1'b0;
			status_q <= drt_pkg::ST_DONE;
		end else begin
			valid_s1 <= cmd.scan;
			if (cmd.exec) begin
				idx_q <= '0;
				unique case (op_q)
					drt_pkg::OP_ADD: begin
						hit_q <= 1'b0;
						if (empty_add) begin
							status_q <= drt_pkg::ST_EMPTY;
						end else if (full) begin
							ovf_q    <= 1'b1;
							status_q <= drt_pkg::ST_FULL;
						end else begin
							count_q  <= count_q + CW'(1);
							status_q <= drt_pkg::ST_DONE;
						end
					end
					drt_pkg::OP_CLEAR: begin
						count_q  <= '0;
						ovf_q    <= 1'b0;
						hit_q    <= 1'b0;
						status_q <= drt_pkg::ST_DONE;
					end
					drt_pkg::OP_QUERY: begin
						hit_q    <= ovf_q;
						status_q <= drt_pkg::ST_DONE;
					end
					default: begin
						hit_q    <= 1'b0;
						status_q <= drt_pkg::ST_DONE;
					end
				endcase
			end else if (cmd.scan) begin
				idx_q <= idx_q + IW'(1);
			end
			if (!cmd.exec && valid_s1 && overlap) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign stat.scan_need = (op_q == drt_pkg::OP_QUERY) && !ovf_q && (count_q != '0);
	assign stat.last      = (CW'(idx_q) + CW'(1)) == count_q;

	assign count_ext = {5'b00000, count_q};
	assign hit       = hit_q;
	assign status    = status_q;
	assign entries   = count_ext[4:0];

endmodule
`default_nettype wire
